// ===== rtl/ctp_pkg.sv =====
// shared widths and types for the tangent point core
// no dependencies
package ctp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = CoordW - 1;
  localparam int unsigned VecW   = CoordW + 1;      // |p - c| magnitude
  localparam int unsigned DW     = 2 * VecW + 1;    // |v|^2
  localparam int unsigned SqrtW  = VecW;            // isqrt result width
  localparam int unsigned NumW   = 2 * RadW + VecW + 1;
  localparam int unsigned QuotW  = NumW;
  localparam int unsigned RootSteps = SqrtW;
  localparam int unsigned DivSteps  = NumW;

  localparam logic [62:0] QuotCap = 63'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } count_e;

  // per-item data carried along the root chain
  typedef struct packed {
    logic              vld;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [RadW-1:0]   r;
    logic [VecW-1:0]   avx;
    logic [VecW-1:0]   avy;
    logic              vxn;
    logic              vyn;
    logic              vxp;
    logic              vyp;
    logic [DW-1:0]     d;
    logic [DW-1:0]     r2;
    logic [1:0]        cnt;
    logic [DW-1:0]     rad;    // remaining radicand
    logic [SqrtW-1:0]  root;
  } root_t;

  // per-item data carried along the divider chain
  typedef struct packed {
    logic              vld;
    logic [1:0]        cnt;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [DW-1:0]     d;
    logic [3:0]        neg;
    logic [3:0][NumW-1:0] num;
    logic [3:0][DW:0]     rem;
    logic [3:0][QuotW-1:0] quo;
  } div_t;

endpackage

// ===== rtl/circle_tangent_points_core.sv =====
// tangent points from a query point to a circle, pipelined chain of cells
// depends on ctp_pkg, ctp_root_cell, ctp_div_cell
//
// channel   dir  fields (lsb first)
// s_axis    in   center_x, center_y, radius, point_x, point_y
// m_axis    out  tangent_count, first_x, first_y, second_x, second_y
//
// one transfer per cycle; the chain is 3 front stages + 33 root cells
// + 3 product stages + 97 divider stages + 1 output register
// the whole chain advances together and halts when the output register is held
// reset clears the valid bits and the cell registers
module circle_tangent_points_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // center_x, center_y, radius, point_x, point_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // tangent_count, first_x, first_y, second_x, second_y
);

  localparam int unsigned CW = ctp_pkg::CoordW;
  localparam int unsigned VW = ctp_pkg::VecW;
  localparam int unsigned DW = ctp_pkg::DW;
  localparam int unsigned RW = ctp_pkg::RadW;
  localparam int unsigned NW = ctp_pkg::NumW;
  localparam int unsigned RS = ctp_pkg::RootSteps;
  localparam int unsigned DS = ctp_pkg::DivSteps;
  localparam int unsigned HW = (RW + VW) / 2;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: differences
  logic s0_vld_q;
  logic signed [CW-1:0] cx0_q, cy0_q, px0_q, py0_q;
  logic [RW-1:0] r0_q;
  logic signed [VW-1:0] vx0_q, vy0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (en) s0_vld_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx0_q <= s_axis_tdata[31:0];
      cy0_q <= s_axis_tdata[63:32];
      r0_q  <= s_axis_tdata[94:64];
      px0_q <= s_axis_tdata[126:95];
      py0_q <= s_axis_tdata[158:127];
      vx0_q <= VW'($signed(s_axis_tdata[126:95])) - VW'($signed(s_axis_tdata[31:0]));
      vy0_q <= VW'($signed(s_axis_tdata[158:127])) - VW'($signed(s_axis_tdata[63:32]));
    end
  end

  // stage 1: magnitudes and squares
  logic s1_vld_q;
  logic [CW-1:0] cx1_q, cy1_q, px1_q, py1_q;
  logic [RW-1:0] r1_q;
  logic [VW-1:0] ax1_q, ay1_q;
  logic xn1_q, yn1_q, xp1_q, yp1_q;
  logic [DW-2:0] sx1_q, sy1_q;
  logic [DW-1:0] r21_q;
  logic [VW-1:0] ax0, ay0;
  assign ax0 = vx0_q[VW-1] ? VW'(-vx0_q) : VW'(vx0_q);
  assign ay0 = vy0_q[VW-1] ? VW'(-vy0_q) : VW'(vy0_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= s0_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q <= cx0_q; cy1_q <= cy0_q; px1_q <= px0_q; py1_q <= py0_q; r1_q <= r0_q;
      ax1_q <= ax0; ay1_q <= ay0;
      xn1_q <= vx0_q[VW-1]; yn1_q <= vy0_q[VW-1];
      xp1_q <= !vx0_q[VW-1] && (vx0_q != '0);
      yp1_q <= !vy0_q[VW-1] && (vy0_q != '0);
      sx1_q <= (DW-1)'(ax0) * (DW-1)'(ax0);
      sy1_q <= (DW-1)'(ay0) * (DW-1)'(ay0);
      r21_q <= DW'(r0_q) * DW'(r0_q);
    end
  end

  // stage 2: distance squared and compare
  ctp_pkg::root_t root_in;
  logic [DW-1:0] dsum;
  assign dsum = DW'(sx1_q) + DW'(sy1_q);
  always_comb begin
    root_in      = '0;
    root_in.vld  = s1_vld_q;
    root_in.cx   = cx1_q; root_in.cy = cy1_q;
    root_in.px   = px1_q; root_in.py = py1_q;
    root_in.r    = r1_q;
    root_in.avx  = ax1_q; root_in.avy = ay1_q;
    root_in.vxn  = xn1_q; root_in.vyn = yn1_q;
    root_in.vxp  = xp1_q; root_in.vyp = yp1_q;
    root_in.d    = dsum;
    root_in.r2   = r21_q;
    if (dsum == r21_q) root_in.cnt = ctp_pkg::CNT_ONE;
    else if (dsum < r21_q) root_in.cnt = ctp_pkg::CNT_NONE;
    else root_in.cnt = ctp_pkg::CNT_TWO;
    root_in.rad  = (dsum > r21_q) ? dsum - r21_q : '0;
    root_in.root = '0;
  end

  ctp_pkg::root_t root0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) root0_q <= '0;
    else if (en) root0_q <= root_in;
  end

  ctp_pkg::root_t rc [RS+1];
  assign rc[0] = root0_q;

  for (genvar g = 0; g < RS; g++) begin : g_root
    ctp_root_cell u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en),
      .bit_i (6'(RS - 1 - g)),
      .a_i   (rc[g]), .a_o(rc[g+1])
    );
  end

  // r*s, then split partial products, then the full products
  ctp_pkg::root_t rf;
  assign rf = rc[RS];
  ctp_pkg::root_t m1_q, m2_q, m3_q;
  logic [RW+VW-1:0] rs_q;
  logic [RW+VW-1:0] axl_q, axh_q, ayl_q, ayh_q;
  logic [HW+VW-1:0] bxl_q, bxh_q, byl_q, byh_q;
  logic [NW-1:0] ax_q, ay_q, bx_q, by_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
    end else if (en) begin
      m1_q <= rf;
      m2_q <= m1_q;
      m3_q <= m2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q  <= (RW+VW)'(rf.r) * (RW+VW)'(rf.root);
      axl_q <= (RW+VW)'(m1_q.r2[RW-1:0]) * (RW+VW)'(m1_q.avx);
      axh_q <= (RW+VW)'(m1_q.r2[2*RW-1:RW]) * (RW+VW)'(m1_q.avx);
      ayl_q <= (RW+VW)'(m1_q.r2[RW-1:0]) * (RW+VW)'(m1_q.avy);
      ayh_q <= (RW+VW)'(m1_q.r2[2*RW-1:RW]) * (RW+VW)'(m1_q.avy);
      bxl_q <= (HW+VW)'(rs_q[HW-1:0]) * (HW+VW)'(m1_q.avx);
      bxh_q <= (HW+VW)'(rs_q[2*HW-1:HW]) * (HW+VW)'(m1_q.avx);
      byl_q <= (HW+VW)'(rs_q[HW-1:0]) * (HW+VW)'(m1_q.avy);
      byh_q <= (HW+VW)'(rs_q[2*HW-1:HW]) * (HW+VW)'(m1_q.avy);
      ax_q  <= NW'(axl_q) + (NW'(axh_q) << RW);
      ay_q  <= NW'(ayl_q) + (NW'(ayh_q) << RW);
      bx_q  <= NW'(bxl_q) + (NW'(bxh_q) << HW);
      by_q  <= NW'(byl_q) + (NW'(byh_q) << HW);
    end
  end

  // signed combine into magnitude and sign
  function automatic logic [NW:0] comb(input logic [NW-1:0] a, input logic an,
                                       input logic [NW-1:0] b, input logic bn);
    logic [NW-1:0] m;
    logic n;
    begin
      if (an == bn) begin
        m = a + b; n = an;
      end else if (a >= b) begin
        m = a - b; n = an;
      end else begin
        m = b - a; n = bn;
      end
      comb = {n, m};
    end
  endfunction

  ctp_pkg::div_t div_in;
  logic [NW:0] c0, c1, c2, c3;
  assign c0 = comb(ax_q, m3_q.vxn, by_q, m3_q.vyp);
  assign c1 = comb(ay_q, m3_q.vyn, bx_q, m3_q.vxn);
  assign c2 = comb(ax_q, m3_q.vxn, by_q, m3_q.vyn);
  assign c3 = comb(ay_q, m3_q.vyn, bx_q, m3_q.vxp);
  always_comb begin
    div_in = '0;
    div_in.vld = m3_q.vld;
    div_in.cnt = m3_q.cnt;
    div_in.px = m3_q.px; div_in.py = m3_q.py;
    div_in.cx = m3_q.cx; div_in.cy = m3_q.cy;
    div_in.d  = (m3_q.cnt == ctp_pkg::CNT_TWO) ? m3_q.d : DW'(1);
    div_in.num[0] = c0[NW-1:0]; div_in.neg[0] = c0[NW];
    div_in.num[1] = c1[NW-1:0]; div_in.neg[1] = c1[NW];
    div_in.num[2] = c2[NW-1:0]; div_in.neg[2] = c2[NW];
    div_in.num[3] = c3[NW-1:0]; div_in.neg[3] = c3[NW];
  end

  ctp_pkg::div_t div0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div0_q <= '0;
    else if (en) div0_q <= div_in;
  end

  ctp_pkg::div_t dc [DS+1];
  assign dc[0] = div0_q;

  for (genvar g = 0; g < DS; g++) begin : g_div
    ctp_div_cell u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en),
      .bit_i (7'(DS - 1 - g)),
      .a_i   (dc[g]), .a_o(dc[g+1])
    );
  end

  // rounding, offset, saturation
  ctp_pkg::div_t df;
  assign df = dc[DS];
  function automatic logic [CW-1:0] fin(input logic [NW-1:0] quo, input logic [DW:0] rem,
                                        input logic [DW-1:0] d, input logic n,
                                        input logic [CW-1:0] c);
    logic [62:0] q;
    logic signed [65:0] v;
    begin
      if (quo > NW'(ctp_pkg::QuotCap)) q = ctp_pkg::QuotCap;
      else q = quo[62:0];
      if ({rem, 1'b0} >= {2'b0, d} && q < ctp_pkg::QuotCap) q = q + 63'd1;
      v = n ? -$signed({3'b0, q}) : $signed({3'b0, q});
      v = v + 66'($signed(c));
      if (v > 66'sd2147483647) fin = {1'b0, {(CW-1){1'b1}}};
      else if (v < -66'sd2147483648) fin = {1'b1, {(CW-1){1'b0}}};
      else fin = v[CW-1:0];
    end
  endfunction

  logic o_vld_q;
  logic [135:0] o_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (en) o_vld_q <= df.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      case (df.cnt)
        ctp_pkg::CNT_TWO: o_q <= {
          6'd0,
          fin(df.quo[3], df.rem[3], df.d, df.neg[3], df.cy),
          fin(df.quo[2], df.rem[2], df.d, df.neg[2], df.cx),
          fin(df.quo[1], df.rem[1], df.d, df.neg[1], df.cy),
          fin(df.quo[0], df.rem[0], df.d, df.neg[0], df.cx),
          df.cnt};
        ctp_pkg::CNT_ONE: o_q <= {6'd0, 64'd0, df.py, df.px, df.cnt};
        default: o_q <= '0;
      endcase
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad count");
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == ctp_pkg::CNT_NONE) |-> m_axis_tdata[135:2] == '0)
    else $error("inside result not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed while held");
`endif

endmodule

// ===== rtl/ctp_root_cell.sv =====
// one restoring square root step, one result bit per cell
// depends on ctp_pkg
module ctp_root_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [5:0]    bit_i,
  input  ctp_pkg::root_t a_i,
  output ctp_pkg::root_t a_o
);

  ctp_pkg::root_t a_d, a_q;
  logic [ctp_pkg::DW+1:0] trial;
  logic [ctp_pkg::DW+1:0] bitw;

  always_comb begin
    a_d   = a_i;
    bitw  = '0;
    bitw[{bit_i, 1'b0}] = 1'b1;
    trial = ({2'b0, ctp_pkg::DW'(a_i.root)} << (bit_i + 6'd1)) + bitw;
    if ({2'b0, a_i.rad} >= trial) begin
      a_d.rad  = a_i.rad - ctp_pkg::DW'(trial);
      a_d.root = a_i.root | (ctp_pkg::SqrtW'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule

// ===== rtl/ctp_div_cell.sv =====
// one restoring division step for the four tangent offsets
// depends on ctp_pkg
module ctp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [6:0]    bit_i,
  input  ctp_pkg::div_t a_i,
  output ctp_pkg::div_t a_o
);

  ctp_pkg::div_t a_d, a_q;
  logic [ctp_pkg::DW:0] sh;

  always_comb begin
    a_d = a_i;
    sh  = '0;
    for (int k = 0; k < 4; k++) begin
      sh = {a_i.rem[k][ctp_pkg::DW-1:0], a_i.num[k][bit_i]};
      a_d.quo[k] = {a_i.quo[k][ctp_pkg::QuotW-2:0], 1'b0};
      if (sh >= {1'b0, a_i.d}) begin
        a_d.rem[k] = sh - {1'b0, a_i.d};
        a_d.quo[k][0] = 1'b1;
      end else begin
        a_d.rem[k] = sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for circle_tangent_points_core: directed table, then random
// queries, checked against table values or a wide-integer model of the tangent math
// depends on ctp_pkg and the core rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [191:0] big_t;

  typedef struct packed {
    ctp_pkg::count_e cnt;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] sx;
    logic [31:0] sy;
  } tangent_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [30:0] r;
    logic [31:0] px;
    logic [31:0] py;
  } query_t;

  typedef struct {
    query_t   q;
    bit       typed;
    tangent_t want;
  } dir_row_t;

  localparam logic [31:0] SMAX = 32'h7fff_ffff;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [30:0] RMAX = 31'h7fff_ffff;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam int N_RANDOM   = 1250;
  localparam int WATCHDOG   = 20000;
  localparam int LONG_HOLD  = 500;
  localparam int DRAIN      = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;

  tangent_t expected_q[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  bit       long_hold_done = 1'b0;

  circle_tangent_points_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] clamp_coord(longint v);
    if (v > longint'(32'sh7fff_ffff)) return SMAX;
    if (v < -longint'(64'h8000_0000)) return SMIN;
    return v[31:0];
  endfunction

  // round((+-r2*am +- rs*bm) / d), nearest, ties away from zero, capped at 2^62
  function automatic longint round_offset(big_t r2, big_t rs, big_t d, longint unsigned am,
                                          bit aneg, longint unsigned bm, bit bneg);
    big_t a, b, num, quo, rem, cap;
    bit   neg;
    a   = r2 * big_t'(am);
    b   = rs * big_t'(bm);
    cap = big_t'(64'h4000_0000_0000_0000);
    if (aneg == bneg) begin
      num = a + b;
      neg = aneg;
    end else if (a >= b) begin
      num = a - b;
      neg = aneg;
    end else begin
      num = b - a;
      neg = bneg;
    end
    quo = num / d;
    rem = num % d;
    if (quo > cap) quo = cap;
    if ((rem << 1) >= d && quo < cap) quo = quo + 1;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic tangent_t predict_tangents(query_t q);
    tangent_t        t;
    longint          cx, cy, px, py, vx, vy;
    longint unsigned avx, avy;
    big_t            d, r2, x, s, cand, rs;
    cx  = longint'($signed(q.cx));
    cy  = longint'($signed(q.cy));
    px  = longint'($signed(q.px));
    py  = longint'($signed(q.py));
    vx  = px - cx;
    vy  = py - cy;
    avx = vx < 0 ? -vx : vx;
    avy = vy < 0 ? -vy : vy;
    d   = big_t'(avx) * big_t'(avx) + big_t'(avy) * big_t'(avy);
    r2  = big_t'(q.r) * big_t'(q.r);
    t   = '0;
    if (d == r2) begin
      t.cnt = ctp_pkg::CNT_ONE;
      t.fx  = q.px;
      t.fy  = q.py;
    end else if (d < r2) begin
      t.cnt = ctp_pkg::CNT_NONE;
    end else begin
      x = d - r2;
      s = '0;
      for (int b = 56; b >= 0; b--) begin
        cand = s | (big_t'(1) << b);
        if (cand * cand <= x) s = cand;
      end
      rs    = big_t'(q.r) * s;
      t.cnt = ctp_pkg::CNT_TWO;
      t.fx  = clamp_coord(cx + round_offset(r2, rs, d, avx, vx < 0, avy, vy > 0));
      t.fy  = clamp_coord(cy + round_offset(r2, rs, d, avy, vy < 0, avx, vx < 0));
      t.sx  = clamp_coord(cx + round_offset(r2, rs, d, avx, vx < 0, avy, vy < 0));
      t.sy  = clamp_coord(cy + round_offset(r2, rs, d, avy, vy < 0, avx, vx > 0));
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] rand_signed(int bits);
    logic [31:0] v;
    v = $urandom_range((1 << bits) - 1);
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  function automatic query_t random_query();
    query_t      q;
    int          mode;
    logic [31:0] k, a, b;
    mode = $urandom_range(99);
    q.cx = $urandom();
    q.cy = $urandom();
    q.r  = 31'($urandom());
    q.px = $urandom();
    q.py = $urandom();
    if (mode < 20) begin
      // full range, any bit pattern
    end else if (mode < 50) begin
      q.cx = rand_signed(20);
      q.cy = rand_signed(20);
      q.r  = 31'($urandom_range(1 << 18));
      q.px = q.cx + rand_signed(19);
      q.py = q.cy + rand_signed(19);
    end else if (mode < 80) begin
      // on the circle via pythagorean triples, optionally nudged off it
      k    = $urandom_range(1 << 20, 1);
      a    = 3 * k;
      b    = 4 * k;
      q.r  = 31'(5 * k);
      if ($urandom_range(1)) {a, b} = {b, a};
      if ($urandom_range(3) == 0) begin
        a = 32'(q.r);
        b = 32'd0;
      end
      if ($urandom_range(1)) a = -a;
      if ($urandom_range(1)) b = -b;
      q.cx = rand_signed(28);
      q.cy = rand_signed(28);
      q.px = q.cx + a;
      q.py = q.cy + b;
      if (mode >= 65) q.px = q.px + (($urandom_range(1) != 0) ? 32'd1 : -32'd1);
    end else if (mode < 90) begin
      if ($urandom_range(1)) q.r = 31'd0;
      else begin
        q.px = q.cx;
        q.py = q.cy;
      end
    end else begin
      q.r  = 31'(RMAX - $urandom_range(1000));
      q.cx = ($urandom_range(1) != 0) ? SMAX - $urandom_range(9) : SMIN + $urandom_range(9);
      q.cy = ($urandom_range(1) != 0) ? SMAX - $urandom_range(9) : SMIN + $urandom_range(9);
    end
    return q;
  endfunction

  task automatic send_query(query_t q, tangent_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, q.py, q.px, q.r, q.cy, q.cx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // result check
  always @(posedge clk_i) begin
    tangent_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cnt = ctp_pkg::count_e'(m_axis_tdata[1:0]);
      got.fx  = m_axis_tdata[33:2];
      got.fy  = m_axis_tdata[65:34];
      got.sx  = m_axis_tdata[97:66];
      got.sy  = m_axis_tdata[129:98];
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: cnt %0d/%0d first %h,%h/%h,%h second %h,%h/%h,%h",
                     want.cnt, got.cnt, want.fx, want.fy, got.fx, got.fy,
                     want.sx, want.sy, got.sx, got.sy);
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && quiet_cycles >= WATCHDOG) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      n = ($urandom_range(3) == 0) ? pick_gap() : 0;
      if (results_seen > 900 && results_seen < 1000) n = 0;
      if (n > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    query_t   q;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // point at center, zero radius: on the circle
    rows.push_back('{'{32'd0, 32'd0, 31'd0, 32'd0, 32'd0}, 1'b1,
                     '{ctp_pkg::CNT_ONE, 32'd0, 32'd0, 32'd0, 32'd0}});
    // inside
    rows.push_back('{'{32'd0, 32'd0, 31'(ONE), 32'd5, 32'd0}, 1'b1,
                     '{ctp_pkg::CNT_NONE, 32'd0, 32'd0, 32'd0, 32'd0}});
    rows.push_back('{'{SMAX, SMIN, RMAX, SMAX, SMIN}, 1'b1,
                     '{ctp_pkg::CNT_NONE, 32'd0, 32'd0, 32'd0, 32'd0}});
    // exactly on the circle
    rows.push_back('{'{32'd0, 32'd0, 31'(ONE), ONE, 32'd0}, 1'b1,
                     '{ctp_pkg::CNT_ONE, ONE, 32'd0, 32'd0, 32'd0}});
    rows.push_back('{'{ONE, ONE, 31'd5, ONE + 3, ONE - 4}, 1'b1,
                     '{ctp_pkg::CNT_ONE, ONE + 3, ONE - 4, 32'd0, 32'd0}});
    // zero radius, point elsewhere: both tangent points at the center
    rows.push_back('{'{32'd1, 32'd2, 31'd0, 32'd5, 32'd7}, 1'b1,
                     '{ctp_pkg::CNT_TWO, 32'd1, 32'd2, 32'd1, 32'd2}});
    rows.push_back('{'{SMIN, SMAX, 31'd0, SMAX, SMIN}, 1'b1,
                     '{ctp_pkg::CNT_TWO, SMIN, SMAX, SMIN, SMAX}});
    // outside, checked by the predictor
    rows.push_back('{'{32'd0, 32'd0, 31'(ONE), 2 * ONE, 32'd0}, 1'b0, '0});
    rows.push_back('{'{32'd0, 32'd0, 31'(ONE), 32'd0, -2 * ONE}, 1'b0, '0});
    rows.push_back('{'{SMIN, SMIN, RMAX, SMAX, SMAX}, 1'b0, '0});
    rows.push_back('{'{SMAX, SMAX, RMAX, SMIN, SMIN}, 1'b0, '0});
    rows.push_back('{'{SMIN, SMAX, RMAX, SMAX, SMIN}, 1'b0, '0});
    rows.push_back('{'{SMAX, 32'd0, 31'd1, SMIN, 32'd0}, 1'b0, '0});
    rows.push_back('{'{32'd0, SMIN, RMAX, 32'd0, SMAX}, 1'b0, '0});
    rows.push_back('{'{-ONE, -ONE, 31'd3, 32'd7, -32'd9}, 1'b0, '0});
    rows.push_back('{'{32'hffff_ffff, 32'hffff_ffff, RMAX, 32'hffff_ffff, SMAX}, 1'b0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      send_query(row.q, row.typed ? row.want : predict_tangents(row.q));
      idle_sender(pick_gap());
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 600) begin
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk_i);
      end
      q = random_query();
      send_query(q, predict_tangents(q));
      if (i < 150 || i > 900) idle_sender(pick_gap());
      else if (i > 300) idle_sender(($urandom_range(2) == 0) ? pick_gap() : 0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== circle_tangent_points_core.f =====
rtl/ctp_pkg.sv
rtl/ctp_root_cell.sv
rtl/ctp_div_cell.sv
rtl/circle_tangent_points_core.sv
tb/tb.sv
